// File: hdl/rtc_pkg.sv
// Package for the seconds-count real-time clock.
// Holds payload structs, calendar constants and the month-length function.
// No dependencies.
package rtc_pkg;

    localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
    localparam logic [31:0] SECS_DAY         = 32'd86400;
    localparam logic [31:0] SECS_HOUR        = 32'd3600;
    localparam logic [31:0] SECS_TEN_MINUTES = 32'd600;
    localparam logic [31:0] SECS_MINUTE      = 32'd60;
    localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
    localparam logic [11:0] LAST_SET_YEAR    = 12'd2099;
    localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;
    localparam logic        CMD_TICK         = 1'b0;
    localparam logic        CMD_SET          = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } rtc_in_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        set_error;
    } rtc_out_t;

    // The clock only reaches years 1970 to 2106, where 2100 is the one
    // century year that is not a leap year.
    function automatic logic is_leap(input logic [11:0] y);
        begin
            is_leap = (y[1:0] == 2'd0) && (y != NON_LEAP_CENTURY);
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
        begin
            case (m0)
                4'd1:    month_len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
                default: month_len = 5'd31;
            endcase
        end
    endfunction

endpackage

// File: hdl/rtc_seconds_calendar.sv
// Seconds-count real-time clock with calendar decode.
// A tick or a refused set is decoded from the count by the shared unit, stepping one year, month,
// day, hour, ten minutes or minute per cycle; a set first builds the count from the date.
// One item at a time; a new item enters only as the previous result is taken.
// Reset (aresetn low, synchronous) clears the count to 1970-01-01 00:00:00.
module rtc_seconds_calendar (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rtc_pkg::rtc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rtc_pkg::rtc_out_t m_data
);
    import rtc_pkg::*;

    logic     busy, done;
    rtc_out_t res;
    logic     m_valid_reg;
    rtc_out_t m_data_reg;

    assign s_ready = !busy && !done && (!m_valid_reg || m_ready);

    rtc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_valid && s_ready),
        .item    (s_data),
        .busy    (busy),
        .done    (done),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

// File: hdl/rtc_seq.sv
// Sequencer with one shared 32-bit add/subtract-compare unit.
// Builds a seconds count from a date and splits a count back into a date.
// Depends on rtc_pkg.
module rtc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  rtc_pkg::rtc_in_t  item,
    output logic              busy,
    output logic              done,
    output rtc_pkg::rtc_out_t result
);
    import rtc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SYR  = 7'b0000010,
        ST_SMO  = 7'b0000100,
        ST_SRST = 7'b0001000,
        ST_DYR  = 7'b0010000,
        ST_DMO  = 7'b0100000,
        ST_DDAY = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  days_reg, days_next;
    logic [11:0] yr_reg, yr_next;
    logic [3:0]  mo_reg, mo_next;
    logic [1:0]  fld_reg, fld_next;
    logic        err_reg, err_next;
    rtc_in_t     in_reg, in_next;
    rtc_out_t    res_reg, res_next;
    logic        done_reg, done_next;

    logic [31:0] op_a, op_b, sum, diff;
    logic        ge;
    logic        leap_now;

    assign leap_now = is_leap(yr_reg);
    assign sum  = op_a + op_b;
    assign diff = op_a - op_b;
    assign ge   = op_a >= op_b;

    always_comb begin
        op_a = acc_reg;
        op_b = 32'd0;
        case (state_reg)
            ST_SYR:  op_b = leap_now ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            ST_SMO:  op_b = 32'(month_len(mo_reg, leap_now)) * SECS_DAY;
            ST_SRST: begin
                case (fld_reg)
                    2'd0:    op_b = (32'(in_reg.set_day) - 32'd1) * SECS_DAY;
                    2'd1:    op_b = 32'(in_reg.set_hour) * SECS_HOUR;
                    2'd2:    op_b = 32'(in_reg.set_minute) * SECS_MINUTE;
                    default: op_b = 32'(in_reg.set_second);
                endcase
            end
            ST_DYR:  op_b = leap_now ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            ST_DMO:  op_b = 32'(month_len(mo_reg, leap_now)) * SECS_DAY;
            ST_DDAY: begin
                case (fld_reg)
                    2'd0:    op_b = SECS_DAY;
                    2'd1:    op_b = SECS_HOUR;
                    2'd2:    op_b = SECS_TEN_MINUTES;
                    default: op_b = SECS_MINUTE;
                endcase
            end
            default: op_b = 32'd0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        days_next  = days_reg;
        yr_next    = yr_reg;
        mo_next    = mo_reg;
        fld_next   = fld_reg;
        err_next   = err_reg;
        in_next    = in_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    in_next  = item;
                    err_next = 1'b0;
                    yr_next  = EPOCH_YEAR;
                    mo_next  = 4'd0;
                    fld_next = 2'd0;
                    if (item.cmd == CMD_TICK) begin
                        count_next = count_reg + 32'd1;
                        acc_next   = count_reg + 32'd1;
                        state_next = ST_DYR;
                    end else if (item.set_year < EPOCH_YEAR || item.set_year > LAST_SET_YEAR
                                 || item.set_month < 4'd1 || item.set_month > 4'd12) begin
                        err_next   = 1'b1;
                        acc_next   = count_reg;
                        state_next = ST_DYR;
                    end else begin
                        acc_next   = 32'd0;
                        state_next = ST_SYR;
                    end
                end
            end
            ST_SYR: begin
                if (yr_reg == in_reg.set_year) begin
                    state_next = ST_SMO;
                end else begin
                    acc_next = sum;
                    yr_next  = yr_reg + 12'd1;
                end
            end
            ST_SMO: begin
                if (mo_reg + 4'd1 >= in_reg.set_month) begin
                    state_next = ST_SRST;
                end else begin
                    acc_next = sum;
                    mo_next  = mo_reg + 4'd1;
                end
            end
            ST_SRST: begin
                acc_next = sum;
                if (fld_reg == 2'd3) begin
                    count_next = sum;
                    fld_next   = 2'd0;
                    yr_next    = EPOCH_YEAR;
                    mo_next    = 4'd0;
                    state_next = ST_DYR;
                end else begin
                    fld_next = fld_reg + 2'd1;
                end
            end
            ST_DYR: begin
                if (ge) begin
                    acc_next = diff;
                    yr_next  = yr_reg + 12'd1;
                end else begin
                    state_next = ST_DMO;
                end
            end
            ST_DMO: begin
                if (mo_reg < 4'd11 && ge) begin
                    acc_next = diff;
                    mo_next  = mo_reg + 4'd1;
                end else begin
                    days_next       = 5'd0;
                    res_next.hour   = 5'd0;
                    res_next.minute = 6'd0;
                    fld_next        = 2'd0;
                    state_next      = ST_DDAY;
                end
            end
            ST_DDAY: begin
                // Repeated subtraction: days, hours, tens of minutes, then minutes.
                if (ge) begin
                    acc_next = diff;
                    case (fld_reg)
                        2'd0:    days_next = days_reg + 5'd1;
                        2'd1:    res_next.hour = res_reg.hour + 5'd1;
                        2'd2:    res_next.minute = res_reg.minute + 6'd10;
                        default: res_next.minute = res_reg.minute + 6'd1;
                    endcase
                end else if (fld_reg == 2'd3) begin
                    res_next.second    = acc_reg[5:0];
                    res_next.year      = yr_reg;
                    res_next.month     = mo_reg + 4'd1;
                    res_next.day       = days_reg + 5'd1;
                    res_next.set_error = err_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    fld_next = fld_reg + 2'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= 32'd0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
        acc_reg  <= acc_next;
        days_reg <= days_next;
        yr_reg   <= yr_next;
        mo_reg   <= mo_next;
        fld_reg  <= fld_next;
        err_reg  <= err_next;
        in_reg   <= in_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_done_after_time: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(state_reg) == ST_DDAY)
        else $error("done without time step");
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (result.month >= 4'd1 && result.month <= 4'd12))
        else $error("month out of range");
    a_err_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && start && item.cmd == CMD_SET && item.set_month == 4'd0)
        |=> $stable(count_reg))
        else $error("refused set changed count");
endmodule

// File: test/tb_rtc_seconds_calendar.sv
// Testbench for the seconds-count real-time clock with calendar decode.
// Drives ticks and sets, predicts each calendar result and checks every transfer.
// Depends on rtc_pkg and rtc_seconds_calendar.
module tb_rtc_seconds_calendar;
    import rtc_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rtc_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rtc_out_t m_data;

    rtc_seconds_calendar dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rtc_in_t     pending_cmds[$];
    rtc_out_t    expected_times[$];
    logic [31:0] clock_secs;
    int          send_gap;
    int          stall_left;
    bit          quiet;
    bit          hold_send;
    bit          failed;
    bit          stim_done;
    int          cycle_count;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m0);
        int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        return lens[m0] + ((m0 == 1 && leap_year(y)) ? 1 : 0);
    endfunction

    function automatic rtc_out_t advance_clock(rtc_in_t c);
        rtc_out_t    r;
        logic [31:0] acc;
        int unsigned days;
        int unsigned rem_s;
        int unsigned y;
        int unsigned m0;
        r = '0;
        if (c.cmd == CMD_TICK) begin
            clock_secs = clock_secs + 32'd1;
        end else if (c.set_year < 1970 || c.set_year > 2099 || c.set_month < 1
                     || c.set_month > 12) begin
            r.set_error = 1'b1;
        end else begin
            acc = 32'd0;
            for (int unsigned t = 1970; t < c.set_year; t++)
                acc += leap_year(t) ? 32'd31622400 : 32'd31536000;
            for (int unsigned t = 0; t + 1 < c.set_month; t++)
                acc += days_in_month(c.set_year, t) * 32'd86400;
            acc += (32'(c.set_day) - 32'd1) * 32'd86400;
            acc += 32'(c.set_hour) * 32'd3600 + 32'(c.set_minute) * 32'd60;
            acc += 32'(c.set_second);
            clock_secs = acc;
        end
        days = clock_secs / 86400;
        rem_s = clock_secs % 86400;
        y = 1970;
        while (days >= (leap_year(y) ? 366 : 365)) begin
            days -= leap_year(y) ? 366 : 365;
            y++;
        end
        m0 = 0;
        while (m0 < 11 && days >= days_in_month(y, m0)) begin
            days -= days_in_month(y, m0);
            m0++;
        end
        r.year = 12'(y);
        r.month = 4'(m0 + 1);
        r.day = 5'(days + 1);
        r.hour = 5'(rem_s / 3600);
        r.minute = 6'((rem_s % 3600) / 60);
        r.second = 6'(rem_s % 60);
        return r;
    endfunction

    function automatic rtc_in_t make_set(int y, int mo, int d, int h, int mi, int s);
        rtc_in_t c;
        c.cmd = CMD_SET;
        c.set_year = 12'(y);
        c.set_month = 4'(mo);
        c.set_day = 5'(d);
        c.set_hour = 5'(h);
        c.set_minute = 6'(mi);
        c.set_second = 6'(s);
        return c;
    endfunction

    function automatic rtc_in_t make_tick();
        rtc_in_t c;
        c = rtc_in_t'($urandom);
        c.cmd = CMD_TICK;
        return c;
    endfunction

    function automatic rtc_in_t random_set();
        rtc_in_t c;
        c = rtc_in_t'($urandom);
        c.cmd = CMD_SET;
        if ($urandom_range(9) != 0) begin
            c.set_year = 12'($urandom_range(1970, 2099));
            c.set_month = 4'($urandom_range(1, 12));
            c.set_hour = 5'($urandom_range(23));
            c.set_minute = 6'($urandom_range(59));
            c.set_second = 6'($urandom_range(59));
            if ($urandom_range(3) == 0)
                c.set_second = 6'($urandom_range(56, 59));
        end
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            send_gap <= 0;
        end else if (s_valid && !s_ready) begin
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0 && !(hold_send && expected_times.size() > 0)) begin
            s_data <= pending_cmds.pop_front();
            s_valid <= 1'b1;
            if (!quiet && $urandom_range(5) == 0)
                send_gap <= $urandom_range(1, 7);
        end else begin
            s_valid <= 1'b0;
        end
        if (aresetn && s_valid && s_ready)
            expected_times.push_back(advance_clock(s_data));
    end

    always @(posedge aclk) begin
        rtc_out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_times.size() == 0) begin
                    $error("unexpected transfer %p", m_data);
                    failed = 1'b1;
                end else begin
                    e = expected_times.pop_front();
                    if (m_data.year !== e.year) begin
                        $error("year expected %0d actual %0d", e.year, m_data.year);
                        failed = 1'b1;
                    end
                    if (m_data.month !== e.month) begin
                        $error("month expected %0d actual %0d", e.month, m_data.month);
                        failed = 1'b1;
                    end
                    if (m_data.day !== e.day) begin
                        $error("day expected %0d actual %0d", e.day, m_data.day);
                        failed = 1'b1;
                    end
                    if (m_data.hour !== e.hour) begin
                        $error("hour expected %0d actual %0d", e.hour, m_data.hour);
                        failed = 1'b1;
                    end
                    if (m_data.minute !== e.minute) begin
                        $error("minute expected %0d actual %0d", e.minute, m_data.minute);
                        failed = 1'b1;
                    end
                    if (m_data.second !== e.second) begin
                        $error("second expected %0d actual %0d", e.second, m_data.second);
                        failed = 1'b1;
                    end
                    if (m_data.set_error !== e.set_error) begin
                        $error("set_error expected %0d actual %0d", e.set_error,
                               m_data.set_error);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(5) == 0) begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int n;
        cycle_count = 0;
        failed = 1'b0;
        quiet = 1'b0;
        hold_send = 1'b0;
        stim_done = 1'b0;
        clock_secs = 32'd0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, refused sets, day zero, overflow, leap-year end.
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_set(1970, 1, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(2099, 12, 31, 23, 59, 59));
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_set(1969, 6, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(2100, 6, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(4095, 15, 31, 31, 63, 63));
        pending_cmds.push_back(make_set(2000, 0, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(2000, 13, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(0, 1, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(1970, 1, 0, 0, 0, 0));
        pending_cmds.push_back(make_set(2000, 3, 0, 12, 0, 0));
        pending_cmds.push_back(make_set(2000, 12, 31, 23, 59, 59));
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_set(2024, 2, 29, 23, 59, 59));
        pending_cmds.push_back(make_tick());
        pending_cmds.push_back(make_set(2099, 12, 31, 31, 63, 63));
        pending_cmds.push_back(make_set(2099, 2, 31, 31, 63, 63));
        pending_cmds.push_back(make_set(2106, 2, 7, 6, 28, 15));
        pending_cmds.push_back(make_set(2099, 12, 31, 0, 0, 0));
        pending_cmds.push_back(make_set(2099, 12, 1, 0, 0, 0));
        pending_cmds.push_back(make_set(2098, 1, 1, 0, 0, 0));
        pending_cmds.push_back(make_tick());
        wait (pending_cmds.size() == 0);

        hold_send = 1'b1;
        pending_cmds.push_back(make_tick());
        wait (pending_cmds.size() == 0 && expected_times.size() == 0);
        hold_send = 1'b0;

        for (n = 0; n < 1530; n++) begin
            if (n == 1350) begin
                wait (pending_cmds.size() == 0);
                quiet = 1'b1;
            end
            if ($urandom_range(3) == 0)
                pending_cmds.push_back(random_set());
            else
                pending_cmds.push_back(make_tick());
            if (pending_cmds.size() > 8)
                wait (pending_cmds.size() <= 4);
        end
        wait (pending_cmds.size() == 0);
        @(posedge aclk);
        wait (!s_valid && expected_times.size() == 0);
        repeat (500) @(posedge aclk);
        if (!failed && expected_times.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: rtc_seconds_calendar.f
hdl/rtc_pkg.sv
hdl/rtc_seq.sv
hdl/rtc_seconds_calendar.sv
test/tb_rtc_seconds_calendar.sv
